/* sv/sorted_priority_list_with_cursor_macros.svh */
// ----------------------------------------------------------------------------
// sorted priority list assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_LIST_WITH_CURSOR_MACROS_SVH
`define SORTED_PRIORITY_LIST_WITH_CURSOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// pre implies post in the same cycle
`define SPL_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sorted priority list check failed");

// pre implies post in the next cycle
`define SPL_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sorted priority list check failed");

`else

`define SPL_ASSERT_IMPL(name, pre, post)
`define SPL_ASSERT_NEXT(name, pre, post)

`endif

`endif

/* sv/spl_pkg.sv */
// ----------------------------------------------------------------------------
// spl_pkg
// shared types and constants of the sorted priority list
// ----------------------------------------------------------------------------
package spl_pkg;

    localparam int CAPACITY    = 16;
    localparam int HANDLE_BITS = 16;
    localparam int CUR_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        CMD_INSERT    = 3'd0,
        CMD_REMOVE    = 3'd1,
        CMD_GET_FIRST = 3'd2,
        CMD_GET_NEXT  = 3'd3,
        CMD_CLEAR     = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_END       = 2'd3
    } status_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic capture;   // latch compare flags against the incoming item
        logic do_ins;    // insert applies this cycle
        logic do_rem;    // remove applies this cycle
        logic occupied;  // cell index below entry count
        logic at_count;  // cell index equals entry count
    } cell_ctrl_t;

endpackage

/* sv/spl_cell.sv */
// ----------------------------------------------------------------------------
// spl_cell
// one slot of the list: holds an entry, compares it with the incoming item
// and shifts toward either neighbor on insert or remove
// ----------------------------------------------------------------------------
module spl_cell
    import spl_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_ctrl_t                    ctrl,
    input  logic signed [31:0]            cmp_key,
    input  logic        [HANDLE_BITS-1:0] cmp_handle,
    input  logic signed [31:0]            new_key,
    input  logic        [HANDLE_BITS-1:0] new_handle,
    input  logic signed [31:0]            left_key,
    input  logic        [HANDLE_BITS-1:0] left_handle,
    input  logic signed [31:0]            right_key,
    input  logic        [HANDLE_BITS-1:0] right_handle,
    input  logic                          left_less,
    input  logic                          seen_in,
    output logic signed [31:0]            key_q,
    output logic        [HANDLE_BITS-1:0] handle_q,
    output logic                          less_q,
    output logic                          match_q,
    output logic                          seen_out
);

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_TAKE_LEFT,
        OP_TAKE_RIGHT
    } cell_op_t;

    logic signed [31:0]            key_reg;
    logic        [HANDLE_BITS-1:0] handle_reg;
    logic                          less_reg;
    logic                          match_reg;
    logic                          less_next;
    logic                          match_next;
    cell_op_t                      op;

    assign less_next  = ctrl.occupied && (key_reg < cmp_key);
    assign match_next = ctrl.occupied && (key_reg == cmp_key) && (handle_reg == cmp_handle);

    always_comb
    begin
        op = OP_HOLD;
        if (ctrl.do_ins)
        begin
            // first cell past the equal-or-greater run takes the new entry
            if ((less_reg || ctrl.at_count) && !left_less)
                op = OP_LOAD;
            else if (left_less)
                op = OP_TAKE_LEFT;
        end
        else if (ctrl.do_rem)
        begin
            if (seen_in || match_reg)
                op = OP_TAKE_RIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            less_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            less_reg  <= less_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                key_reg    <= new_key;
                handle_reg <= new_handle;
            end
            OP_TAKE_LEFT:
            begin
                key_reg    <= left_key;
                handle_reg <= left_handle;
            end
            OP_TAKE_RIGHT:
            begin
                key_reg    <= right_key;
                handle_reg <= right_handle;
            end
            default:
            begin
                key_reg    <= key_reg;
                handle_reg <= handle_reg;
            end
        endcase
    end

    assign key_q    = key_reg;
    assign handle_q = handle_reg;
    assign less_q   = less_reg;
    assign match_q  = match_reg;
    assign seen_out = seen_in || match_reg;

endmodule

/* sv/sorted_priority_list_with_cursor.sv */
// ----------------------------------------------------------------------------
// sorted_priority_list_with_cursor
// bounded list of (signed key, handle) entries in descending key order,
// kept in a row of shifting cells, with a read cursor
//
//   channel  signals                          direction
//   input    in_valid in_stall cmd key handle  command in
//   output   out_valid out_stall status        result out
//            out_handle out_key
//
// every command runs in two steps: the transfer cycle latches compare flags
// in all cells at once, then the execute state shifts the row and loads the result
// register. a stalled result holds the block in its execute state; the next
// command is taken while a finished result waits on the output.
// reset is asynchronous and empties the list at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "sorted_priority_list_with_cursor_macros.svh"

module sorted_priority_list_with_cursor
    import spl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] key,
    input  logic [15:0]        handle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [15:0]        out_handle,
    output logic signed [31:0] out_key
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                   state_reg, state_next;
    logic [2:0]               cmd_reg, cmd_next;
    logic signed [31:0]       key_reg, key_next;
    logic [HANDLE_BITS-1:0]   handle_reg, handle_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CUR_W-1:0]         cursor_reg, cursor_next;
    logic                     cvalid_reg, cvalid_next;
    logic                     skip_reg, skip_next;
    logic                     out_valid_reg, out_valid_next;
    status_t                  status_reg, status_next;
    logic [15:0]              out_handle_reg, out_handle_next;
    logic signed [31:0]       out_key_reg, out_key_next;

    logic                     accept;
    logic                     fire;
    logic                     full;
    logic                     found;
    logic [HANDLE_BITS-1:0]   in_handle_st;
    logic [CUR_W:0]           newpos;
    logic [CUR_W-1:0]         rd_idx;

    logic signed [31:0]       cell_key    [CAPACITY];
    logic [HANDLE_BITS-1:0]   cell_handle [CAPACITY];
    logic                     cell_less   [CAPACITY];
    logic                     cell_match  [CAPACITY];
    logic                     cell_seen   [CAPACITY+1];
    cell_ctrl_t               cell_ctrl   [CAPACITY];

    assign in_stall     = (state_reg != S_IDLE);
    assign accept       = in_valid && !in_stall;
    assign fire         = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign full         = (count_reg == CNT_W'(CAPACITY));
    assign in_handle_st = HANDLE_BITS'({{HANDLE_BITS{1'b0}}, handle});
    assign cell_seen[0] = 1'b0;
    assign found        = cell_seen[CAPACITY];

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [31:0]     lk;
            logic [HANDLE_BITS-1:0] lh;
            logic                   ll;
            logic signed [31:0]     rk;
            logic [HANDLE_BITS-1:0] rh;

            if (gi == 0)
            begin : g_head
                assign lk = '0;
                assign lh = '0;
                assign ll = 1'b0;
            end
            else
            begin : g_inner
                assign lk = cell_key[gi-1];
                assign lh = cell_handle[gi-1];
                assign ll = cell_less[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign rk = '0;
                assign rh = '0;
            end
            else
            begin : g_body
                assign rk = cell_key[gi+1];
                assign rh = cell_handle[gi+1];
            end

            assign cell_ctrl[gi].capture  = accept;
            assign cell_ctrl[gi].do_ins   = fire && (cmd_reg == CMD_INSERT) && !full;
            assign cell_ctrl[gi].do_rem   = fire && (cmd_reg == CMD_REMOVE);
            assign cell_ctrl[gi].occupied = (count_reg > CNT_W'(gi));
            assign cell_ctrl[gi].at_count = (count_reg == CNT_W'(gi));

            spl_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (cell_ctrl[gi]),
                .cmp_key      (key),
                .cmp_handle   (in_handle_st),
                .new_key      (key_reg),
                .new_handle   (handle_reg),
                .left_key     (lk),
                .left_handle  (lh),
                .right_key    (rk),
                .right_handle (rh),
                .left_less    (ll),
                .seen_in      (cell_seen[gi]),
                .key_q        (cell_key[gi]),
                .handle_q     (cell_handle[gi]),
                .less_q       (cell_less[gi]),
                .match_q      (cell_match[gi]),
                .seen_out     (cell_seen[gi+1])
            );
        end
    endgenerate

    // position the cursor lands on for get next
    assign newpos = skip_reg ? {1'b0, cursor_reg} : ({1'b0, cursor_reg} + 1'b1);
    assign rd_idx = (cmd_reg == CMD_GET_FIRST) ? '0 : newpos[CUR_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        count_next      = count_reg;
        cursor_next     = cursor_reg;
        cvalid_next     = cvalid_reg;
        skip_next       = skip_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        out_handle_next = out_handle_reg;
        out_key_next    = out_key_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (accept)
        begin
            state_next  = S_EXEC;
            cmd_next    = cmd;
            key_next    = key;
            handle_next = in_handle_st;
        end

        if (fire)
        begin
            state_next      = S_IDLE;
            out_valid_next  = 1'b1;
            status_next     = ST_OK;
            out_handle_next = '0;
            out_key_next    = '0;
            case (cmd_reg)
                CMD_INSERT:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        if (cvalid_reg && cell_less[cursor_reg])
                            cursor_next = cursor_reg + 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (!found)
                        status_next = ST_NOT_FOUND;
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        if (cvalid_reg)
                        begin
                            // removed entry is the one under the cursor
                            if (cell_match[cursor_reg] && !cell_seen[{1'b0, cursor_reg}])
                            begin
                                if (cursor_reg == '0)
                                begin
                                    cvalid_next = (count_reg != CNT_W'(1));
                                    skip_next   = 1'b1;
                                end
                                else
                                    cursor_next = cursor_reg - 1'b1;
                            end
                            else if (cell_seen[{1'b0, cursor_reg}])
                                cursor_next = cursor_reg - 1'b1;
                        end
                    end
                end
                CMD_GET_FIRST:
                begin
                    skip_next   = 1'b0;
                    cursor_next = '0;
                    if (count_reg != '0)
                    begin
                        cvalid_next     = 1'b1;
                        out_handle_next = 16'({{16{1'b0}}, cell_handle[rd_idx]});
                        out_key_next    = cell_key[rd_idx];
                    end
                    else
                    begin
                        cvalid_next = 1'b0;
                        status_next = ST_END;
                    end
                end
                CMD_GET_NEXT:
                begin
                    if (!cvalid_reg)
                        status_next = ST_END;
                    else
                    begin
                        skip_next   = 1'b0;
                        cursor_next = newpos[CUR_W-1:0];
                        if (newpos < (CUR_W+1)'(count_reg))
                        begin
                            out_handle_next = 16'({{16{1'b0}}, cell_handle[rd_idx]});
                            out_key_next    = cell_key[rd_idx];
                        end
                        else
                        begin
                            cvalid_next = 1'b0;
                            status_next = ST_END;
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    count_next  = '0;
                    cursor_next = '0;
                    cvalid_next = 1'b0;
                    skip_next   = 1'b0;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            key_reg        <= '0;
            handle_reg     <= '0;
            count_reg      <= '0;
            cursor_reg     <= '0;
            cvalid_reg     <= 1'b0;
            skip_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            out_handle_reg <= '0;
            out_key_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            key_reg        <= key_next;
            handle_reg     <= handle_next;
            count_reg      <= count_next;
            cursor_reg     <= cursor_next;
            cvalid_reg     <= cvalid_next;
            skip_reg       <= skip_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            out_handle_reg <= out_handle_next;
            out_key_reg    <= out_key_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_handle = out_handle_reg;
    assign out_key    = out_key_reg;

    `SPL_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SPL_ASSERT_IMPL(a_cursor_in_list, cvalid_reg, CNT_W'(cursor_reg) < count_reg)
    `SPL_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == S_EXEC)
    `SPL_ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg && state_reg == S_IDLE)

endmodule

/* tb/sorted_priority_list_with_cursor_tb.sv */
// ----------------------------------------------------------------------------
// sorted_priority_list_with_cursor_tb
// drives insert, remove, cursor walk and clear commands into the list and
// checks every response against a behavioral copy of the list kept here;
// directed corner cases first, then random command sequences under
// several sender and receiver idling patterns
// ----------------------------------------------------------------------------
module sorted_priority_list_with_cursor_tb
    import spl_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 270;
    localparam int DRAIN_CYCLES = 10;
    localparam int PRINT_LIMIT  = 40;

    localparam logic [2:0]         CMD_RSVD_FIRST = 3'd5;
    localparam logic [2:0]         CMD_RSVD_LAST  = 3'd7;
    localparam logic signed [31:0] KEY_MAX        = 32'sh7fffffff;
    localparam logic signed [31:0] KEY_MIN        = 32'sh80000000;

    typedef struct {
        status_t            status;
        logic [15:0]        handle;
        logic signed [31:0] key;
    } response_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [2:0]         cmd        = '0;
    logic signed [31:0] key        = '0;
    logic [15:0]        handle     = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [1:0]         status;
    logic [15:0]        out_handle;
    logic signed [31:0] out_key;

    // behavioral copy of the list
    logic signed [31:0] list_keys    [CAPACITY];
    logic [15:0]        list_handles [CAPACITY];
    int                 list_count   = 0;
    int                 cur_pos      = 0;
    bit                 cur_valid    = 1'b0;
    bit                 skip_pending = 1'b0;

    response_t pending_responses[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int command_count = 0;
    int checked_count = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    sorted_priority_list_with_cursor i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .key        (key),
        .handle     (handle),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .out_handle (out_handle),
        .out_key    (out_key)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycle_count, pending_responses.size());
            $display("sorted_priority_list_with_cursor_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (error_count < PRINT_LIMIT)
            $display("mismatch on response %0d: %s expected %0h got %0h",
                     checked_count, what, want, got);
        error_count++;
    endtask

    // applies one command to the list copy and returns the response it gives
    task automatic predict_list_response(input logic [2:0] op,
                                         input logic signed [31:0] k,
                                         input logic [15:0] h,
                                         output response_t r);
        int pos;
        int i;
        bit read_out;
        r.status = ST_OK;
        r.handle = '0;
        r.key    = '0;
        read_out = 1'b0;
        pos      = 0;
        case (op)
            CMD_INSERT:
            begin
                if (list_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    // new entry lands after every key >= its own
                    while (pos < list_count && list_keys[pos] >= k)
                        pos++;
                    for (i = list_count; i > pos; i--)
                    begin
                        list_keys[i]    = list_keys[i - 1];
                        list_handles[i] = list_handles[i - 1];
                    end
                    list_keys[pos]    = k;
                    list_handles[pos] = h;
                    list_count++;
                    if (cur_valid && cur_pos >= pos)
                        cur_pos++;
                end
            end
            CMD_REMOVE:
            begin
                while (pos < list_count && !(list_keys[pos] == k && list_handles[pos] == h))
                    pos++;
                if (pos >= list_count)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    for (i = pos; i + 1 < list_count; i++)
                    begin
                        list_keys[i]    = list_keys[i + 1];
                        list_handles[i] = list_handles[i + 1];
                    end
                    list_count--;
                    if (cur_valid)
                    begin
                        if (cur_pos == pos)
                        begin
                            if (pos == 0)
                            begin
                                // head under the cursor: go to new head, hold next advance
                                cur_pos      = 0;
                                cur_valid    = list_count > 0;
                                skip_pending = 1'b1;
                            end
                            else
                                cur_pos = pos - 1;
                        end
                        else if (cur_pos > pos)
                            cur_pos--;
                    end
                end
            end
            CMD_GET_FIRST:
            begin
                skip_pending = 1'b0;
                cur_pos      = 0;
                cur_valid    = list_count > 0;
                read_out     = 1'b1;
            end
            CMD_GET_NEXT:
            begin
                if (!cur_valid)
                    r.status = ST_END;
                else
                begin
                    if (skip_pending)
                        skip_pending = 1'b0;
                    else
                        cur_pos++;
                    read_out = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                list_count   = 0;
                cur_pos      = 0;
                cur_valid    = 1'b0;
                skip_pending = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (read_out)
        begin
            if (cur_valid && cur_pos < list_count)
            begin
                r.handle = list_handles[cur_pos];
                r.key    = list_keys[cur_pos];
            end
            else
            begin
                cur_valid = 1'b0;
                r.status  = ST_END;
            end
        end
    endtask

    task automatic send_command(input logic [2:0] op, input logic signed [31:0] k,
                                input logic [15:0] h);
        response_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        key      <= k;
        handle   <= h;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_list_response(op, k, h, r);
        pending_responses.push_back(r);
        if (op <= CMD_CLEAR)
            command_count++;
    endtask

    task automatic wait_all_responses();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_responses.size() != 0);
    endtask

    always @(posedge clk)
    begin : check_response
        response_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_responses.size() == 0)
                report_mismatch("response with none pending, status", '0, status);
            else
            begin
                want = pending_responses.pop_front();
                if (status !== want.status)
                    report_mismatch("status", want.status, status);
                if (out_handle !== want.handle)
                    report_mismatch("out_handle", want.handle, out_handle);
                if (out_key !== want.key)
                    report_mismatch("out_key", want.key, out_key);
            end
            if (!$isunknown(status))
                status_seen[status]++;
            checked_count++;
        end
    end

    // mostly small keys so ties and duplicate entries are common
    function automatic logic signed [31:0] rand_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return int'($urandom_range(8)) - 4;
        if (pick < 85)
            return $urandom;
        case ($urandom_range(3))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    function automatic logic [15:0] rand_handle();
        if ($urandom_range(99) < 60)
            return 16'($urandom_range(3));
        return 16'($urandom);
    endfunction

    task automatic remove_existing();
        int idx;
        if (list_count == 0)
            send_command(CMD_REMOVE, rand_key(), rand_handle());
        else
        begin
            idx = $urandom_range(list_count - 1);
            send_command(CMD_REMOVE, list_keys[idx], list_handles[idx]);
        end
    endtask

    task automatic remove_at_cursor();
        if (cur_valid && cur_pos < list_count)
            send_command(CMD_REMOVE, list_keys[cur_pos], list_handles[cur_pos]);
        else
            remove_existing();
    endtask

    task automatic test_empty_list();
        send_command(CMD_GET_FIRST, '0, '0);
        send_command(CMD_GET_NEXT, '0, '0);
        send_command(CMD_REMOVE, 32'sd5, 16'h0001);
        send_command(CMD_CLEAR, '0, '0);
    endtask

    task automatic test_order_and_walk();
        send_command(CMD_INSERT, '0, 16'h0001);
        send_command(CMD_INSERT, KEY_MAX, 16'hffff);
        send_command(CMD_INSERT, KEY_MIN, 16'h0000);
        // equal key goes after the existing one
        send_command(CMD_INSERT, '0, 16'h0002);
        send_command(CMD_INSERT, -32'sd1, 16'h8000);
        send_command(CMD_GET_FIRST, '0, '0);
        repeat (5)
            send_command(CMD_GET_NEXT, '0, '0);
        send_command(CMD_GET_NEXT, '0, '0);
    endtask

    task automatic test_cursor_moves();
        send_command(CMD_GET_FIRST, '0, '0);
        send_command(CMD_REMOVE, KEY_MAX, 16'hffff);
        send_command(CMD_GET_NEXT, '0, '0);
        send_command(CMD_GET_NEXT, '0, '0);
        send_command(CMD_INSERT, 32'sd5, 16'h0005);
        send_command(CMD_GET_NEXT, '0, '0);
        send_command(CMD_REMOVE, '0, 16'h0002);
        send_command(CMD_REMOVE, -32'sd1, 16'h8000);
        send_command(CMD_GET_NEXT, '0, '0);
        // key matches but handle does not
        send_command(CMD_REMOVE, '0, 16'h0003);
    endtask

    task automatic test_unknown_and_clear();
        logic [2:0] op;
        for (op = CMD_RSVD_FIRST; op != CMD_INSERT; op++)
            send_command(op, rand_key(), 16'($urandom));
        send_command(CMD_CLEAR, '0, '0);
        send_command(CMD_GET_FIRST, '0, '0);
        // last entry removed under the cursor: cursor invalid, skip still set
        send_command(CMD_INSERT, 32'sd7, 16'h00aa);
        send_command(CMD_GET_FIRST, '0, '0);
        send_command(CMD_REMOVE, 32'sd7, 16'h00aa);
        send_command(CMD_GET_NEXT, '0, '0);
        send_command(CMD_INSERT, 32'sd8, 16'h00bb);
        send_command(CMD_GET_NEXT, '0, '0);
        send_command(CMD_GET_FIRST, '0, '0);
    endtask

    task automatic random_single_command();
        int pick;
        pick = $urandom_range(19);
        if (pick < 6)
            send_command(CMD_INSERT, rand_key(), rand_handle());
        else if (pick < 9)
            remove_existing();
        else if (pick < 11)
            send_command(CMD_REMOVE, rand_key(), rand_handle());
        else if (pick < 13)
            send_command(CMD_GET_FIRST, rand_key(), rand_handle());
        else if (pick < 17)
            send_command(CMD_GET_NEXT, rand_key(), rand_handle());
        else if (pick == 17)
            send_command(CMD_CLEAR, rand_key(), rand_handle());
        else if (pick == 18)
            send_command(3'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST)),
                         rand_key(), rand_handle());
        else
            remove_at_cursor();
    endtask

    task automatic test_random(input int idle_pct, input int stall_in, input int items);
        int start;
        int kind;
        int pick;
        start         = command_count;
        send_idle_pct = idle_pct;
        stall_pct     = stall_in;
        while (command_count - start < items)
        begin
            kind = $urandom_range(99);
            if (kind < 25)
            begin
                // fill, sometimes past capacity, then walk part or all of the list
                send_command(CMD_CLEAR, '0, '0);
                repeat ($urandom_range(CAPACITY + 2, 1))
                    send_command(CMD_INSERT, rand_key(), rand_handle());
                send_command(CMD_GET_FIRST, '0, '0);
                repeat ($urandom_range(CAPACITY + 1))
                    send_command(CMD_GET_NEXT, '0, '0);
            end
            else if (kind < 60)
            begin
                // cursor walk with edits around it
                send_command(CMD_GET_FIRST, '0, '0);
                repeat ($urandom_range(8, 1))
                begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                        send_command(CMD_GET_NEXT, '0, '0);
                    else if (pick < 70)
                        remove_at_cursor();
                    else if (pick < 85)
                        remove_existing();
                    else
                        send_command(CMD_INSERT, rand_key(), rand_handle());
                end
            end
            else if (kind < 95)
            begin
                repeat (10)
                    random_single_command();
            end
            else
                wait_all_responses();
        end
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_order_and_walk();
        test_cursor_moves();
        test_unknown_and_clear();
        wait_all_responses();
        test_random(0, 0, PHASE_ITEMS);
        test_random(68, 0, PHASE_ITEMS);
        test_random(0, 68, PHASE_ITEMS);
        test_random(21, 21, PHASE_ITEMS);
        wait_all_responses();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("ran %0d list commands plus reserved codes, %0d responses checked, %0d errors",
                 command_count, checked_count, error_count);
        $display("responses seen: ok %0d, not found %0d, full %0d, end or empty %0d",
                 status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_FULL],
                 status_seen[ST_END]);
        if (error_count == 0 && pending_responses.size() == 0)
            $display("sorted_priority_list_with_cursor_tb: PASS");
        else
            $display("sorted_priority_list_with_cursor_tb: FAIL");
        $finish;
    end

endmodule

/* sorted_priority_list_with_cursor.f */
+incdir+sv
sv/spl_pkg.sv
sv/spl_cell.sv
sv/sorted_priority_list_with_cursor.sv
tb/sorted_priority_list_with_cursor_tb.sv
